// ===== rtl/core/vrbf_pkg.sv =====
// shared types, constants and face geometry for the voxel boundary face block
`default_nettype none

package vrbf_pkg;

	// fixed field widths
	localparam int LABEL_W   = 16;
	localparam int VERT_W    = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;

	// parameter defaults
	localparam int DEF_MAX_DIM    = 256;
	localparam int DEF_LABEL_BITS = 16;

	// triangles per voxel, two for each of the three faces
	localparam int NUM_TRI = 6;
	localparam int TRI_W   = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 3'd0,
		REG_SIZE_Y = 3'd1,
		REG_SIZE_Z = 3'd2,
		REG_FLIP   = 3'd3
	} cfg_reg_t;

	// face codes, in emission order
	typedef enum logic [1:0] {
		FACE_Z = 2'd0,
		FACE_Y = 2'd1,
		FACE_X = 2'd2
	} face_t;

	// corner offset {dx,dy,dz} for one face, triangle and vertex (a or b)
	function automatic logic [2:0] face_offset(face_t face, logic tri_sel, logic vtx_b);
		logic [2:0] off;
		off = 3'b000;
		case (face)
			FACE_Z: begin
				case ({tri_sel, vtx_b})
					2'b00:   off = 3'b110;
					2'b01:   off = 3'b100;
					2'b10:   off = 3'b010;
					default: off = 3'b110;
				endcase
			end
			FACE_Y: begin
				case ({tri_sel, vtx_b})
					2'b00:   off = 3'b101;
					2'b01:   off = 3'b001;
					2'b10:   off = 3'b100;
					default: off = 3'b101;
				endcase
			end
			FACE_X: begin
				case ({tri_sel, vtx_b})
					2'b00:   off = 3'b011;
					2'b01:   off = 3'b010;
					2'b10:   off = 3'b001;
					default: off = 3'b011;
				endcase
			end
			default: off = 3'b000;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vrbf_if.sv =====
// voxel input and face output channel interfaces
`default_nettype none

interface vrbf_vox_if;
	import vrbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] region_label;

	modport source (output valid, output region_label, input ready);
	modport sink (input valid, input region_label, output ready);
endinterface

interface vrbf_face_if;
	import vrbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] back_region;
	logic [LABEL_W-1:0] front_region;
	logic [VERT_W-1:0]  v0_x;
	logic [VERT_W-1:0]  v0_y;
	logic [VERT_W-1:0]  v0_z;
	logic [VERT_W-1:0]  v1_x;
	logic [VERT_W-1:0]  v1_y;
	logic [VERT_W-1:0]  v1_z;
	logic [VERT_W-1:0]  v2_x;
	logic [VERT_W-1:0]  v2_y;
	logic [VERT_W-1:0]  v2_z;
	logic               last_of_voxel;

	modport source (
		output valid, output back_region, output front_region,
		output v0_x, output v0_y, output v0_z,
		output v1_x, output v1_y, output v1_z,
		output v2_x, output v2_y, output v2_z,
		output last_of_voxel, input ready
	);
	modport sink (
		input valid, input back_region, input front_region,
		input v0_x, input v0_y, input v0_z,
		input v1_x, input v1_y, input v1_z,
		input v2_x, input v2_y, input v2_z,
		input last_of_voxel, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/voxel_region_boundary_faces.sv =====
// voxel region boundary face extraction, top level
//
// channel   dir  payload                                     transaction
// vox       in   region_label                                one voxel, raster order
// face      out  back/front region, v0..v2, last_of_voxel    one triangle
// cfg       in   cfg_index, cfg_data                         register write on cfg_we
//
// a voxel yields n (0..6) triangles; the single face result register, loaded at most once per
// cycle and held while the face output stalls, passes them on in turn.
// the plane store is read twice and written once at the edge a voxel is accepted;
// its contents need no clearing, reset clears only control state.
// a stalled face output holds its triangle; a new voxel enters only once the voxel
// stage has no triangle left to send.
`default_nettype none

module voxel_region_boundary_faces #(
	parameter int MAX_DIM_X  = vrbf_pkg::DEF_MAX_DIM,
	parameter int MAX_DIM_Y  = vrbf_pkg::DEF_MAX_DIM,
	parameter int MAX_DIM_Z  = vrbf_pkg::DEF_MAX_DIM,
	parameter int LABEL_BITS = vrbf_pkg::DEF_LABEL_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	vrbf_vox_if.sink                            vox,
	vrbf_face_if.source                         face,
	input  wire logic                           cfg_we,
	input  wire logic [vrbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vrbf_pkg::CFG_W-1:0]     cfg_data
);
	import vrbf_pkg::*;

	// position and size widths per axis
	localparam int PX = $clog2(MAX_DIM_X);
	localparam int PY = $clog2(MAX_DIM_Y);
	localparam int PZ = $clog2(MAX_DIM_Z);
	localparam int SX = ($clog2(MAX_DIM_X + 1) > CFG_W) ? $clog2(MAX_DIM_X + 1) : CFG_W;
	localparam int SY = ($clog2(MAX_DIM_Y + 1) > CFG_W) ? $clog2(MAX_DIM_Y + 1) : CFG_W;
	localparam int SZ = ($clog2(MAX_DIM_Z + 1) > CFG_W) ? $clog2(MAX_DIM_Z + 1) : CFG_W;
	localparam int AW = PY + PZ;
	localparam int DEPTH = 1 << AW;

	// configuration registers
	logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;
	logic             flip_q;

	// scan state
	logic [PX-1:0]         pos_x_q, pos_x_nxt;
	logic [PY-1:0]         pos_y_q, pos_y_nxt;
	logic [PZ-1:0]         pos_z_q, pos_z_nxt;
	logic [LABEL_BITS-1:0] prev_q;

	// plane store, one label per (y,z)
	logic [LABEL_BITS-1:0] plane_mem [0:DEPTH-1];
	logic [AW-1:0]         wr_addr, yn_addr;

	// voxel stage
	logic                  valid_s1;
	logic [NUM_TRI-1:0]    done_s1;
	logic [LABEL_BITS-1:0] cur_s1, prev_s1, nby_s1, nbx_s1;
	logic [PX-1:0]         pos_x_s1;
	logic [PY-1:0]         pos_y_s1;
	logic [PZ-1:0]         pos_z_s1;

	// effective sizes and wrap
	logic [SX-1:0] eff_x;
	logic [SY-1:0] eff_y;
	logic [SZ-1:0] eff_z;
	logic          wrap_x, wrap_y, wrap_z;

	// triangle selection
	logic [NUM_TRI-1:0]    tri_mask, rem, pick_oh;
	logic [TRI_W-1:0]      pick_idx;
	logic                  pick_found;
	face_t                 pick_face;
	logic [2:0]            off_a, off_b, off_1, off_2;
	logic                  dz, dy, dx;
	logic                  accept, out_load, s1_finish, last_tri;
	logic [LABEL_BITS-1:0] front_sel;
	logic [VERT_W-1:0]     bx, by, bz;

	// output register
	logic               out_valid_q;
	logic [LABEL_W-1:0] back_q, front_q;
	logic [VERT_W-1:0]  v0x_q, v0y_q, v0z_q, v1x_q, v1y_q, v1z_q, v2x_q, v2y_q, v2z_q;
	logic               last_q;

	// size clamping: zero acts as one, above max acts as max
	always_comb begin
		if (size_x_q == '0) eff_x = SX'(1);
		else if (SX'(size_x_q) > SX'(MAX_DIM_X)) eff_x = SX'(MAX_DIM_X);
		else eff_x = SX'(size_x_q);
		if (size_y_q == '0) eff_y = SY'(1);
		else if (SY'(size_y_q) > SY'(MAX_DIM_Y)) eff_y = SY'(MAX_DIM_Y);
		else eff_y = SY'(size_y_q);
		if (size_z_q == '0) eff_z = SZ'(1);
		else if (SZ'(size_z_q) > SZ'(MAX_DIM_Z)) eff_z = SZ'(MAX_DIM_Z);
		else eff_z = SZ'(size_z_q);
	end

	// raster position advance, z fastest
	always_comb begin
		wrap_z    = (SZ'(pos_z_q) + SZ'(1)) >= eff_z;
		wrap_y    = (SY'(pos_y_q) + SY'(1)) >= eff_y;
		wrap_x    = (SX'(pos_x_q) + SX'(1)) >= eff_x;
		pos_x_nxt = pos_x_q;
		pos_y_nxt = pos_y_q;
		pos_z_nxt = pos_z_q + PZ'(1);
		if (wrap_z) begin
			pos_z_nxt = '0;
			pos_y_nxt = pos_y_q + PY'(1);
			if (wrap_y) begin
				pos_y_nxt = '0;
				pos_x_nxt = wrap_x ? '0 : pos_x_q + PX'(1);
			end
		end
	end

	assign accept  = vox.valid && vox.ready;
	assign wr_addr = {pos_y_q, pos_z_q};
	assign yn_addr = {pos_y_q - PY'(1), pos_z_q};

	// configuration and scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CFG_W'(1);
			size_y_q <= CFG_W'(1);
			size_z_q <= CFG_W'(1);
			flip_q   <= 1'b0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			pos_z_q  <= '0;
			prev_q   <= '0;
		end else begin
			if (accept) begin
				pos_x_q <= pos_x_nxt;
				pos_y_q <= pos_y_nxt;
				pos_z_q <= pos_z_nxt;
				prev_q  <= vox.region_label[LABEL_BITS-1:0];
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SIZE_X: begin
						size_x_q <= cfg_data;
						pos_x_q  <= '0;
						pos_y_q  <= '0;
						pos_z_q  <= '0;
					end
					REG_SIZE_Y: begin
						size_y_q <= cfg_data;
						pos_x_q  <= '0;
						pos_y_q  <= '0;
						pos_z_q  <= '0;
					end
					REG_SIZE_Z: begin
						size_z_q <= cfg_data;
						pos_x_q  <= '0;
						pos_y_q  <= '0;
						pos_z_q  <= '0;
					end
					REG_FLIP: flip_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// plane store access and voxel stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			plane_mem[wr_addr] <= vox.region_label[LABEL_BITS-1:0];
			nbx_s1             <= plane_mem[wr_addr];
			nby_s1             <= plane_mem[yn_addr];
			cur_s1             <= vox.region_label[LABEL_BITS-1:0];
			prev_s1            <= prev_q;
			pos_x_s1           <= pos_x_q;
			pos_y_s1           <= pos_y_q;
			pos_z_s1           <= pos_z_q;
		end
	end

	// boundary tests and lowest pending triangle
	always_comb begin
		dz       = (pos_z_s1 != '0) && (prev_s1 != cur_s1);
		dy       = (pos_y_s1 != '0) && (nby_s1 != cur_s1);
		dx       = (pos_x_s1 != '0) && (nbx_s1 != cur_s1);
		tri_mask = {dx, dx, dy, dy, dz, dz};
		rem      = tri_mask & ~done_s1;
		pick_idx   = '0;
		pick_found = 1'b0;
		for (int i = 0; i < NUM_TRI; i++) begin
			if (rem[i] && !pick_found) begin
				pick_idx   = TRI_W'(i);
				pick_found = 1'b1;
			end
		end
		pick_oh  = NUM_TRI'(1) << pick_idx;
		last_tri = (rem & ~pick_oh) == '0;
		case (pick_idx[TRI_W-1:1])
			2'd0:    pick_face = FACE_Z;
			2'd1:    pick_face = FACE_Y;
			default: pick_face = FACE_X;
		endcase
		case (pick_face)
			FACE_Z:  front_sel = prev_s1;
			FACE_Y:  front_sel = nby_s1;
			default: front_sel = nbx_s1;
		endcase
		off_a = face_offset(pick_face, pick_idx[0], 1'b0);
		off_b = face_offset(pick_face, pick_idx[0], 1'b1);
		off_1 = flip_q ? off_b : off_a;
		off_2 = flip_q ? off_a : off_b;
		bx    = VERT_W'(pos_x_s1);
		by    = VERT_W'(pos_y_s1);
		bz    = VERT_W'(pos_z_s1);
	end

	// stage handshake
	assign out_load  = valid_s1 && pick_found && (!out_valid_q || face.ready);
	assign s1_finish = valid_s1 && (!pick_found || (out_load && last_tri));
	assign vox.ready = !valid_s1 || s1_finish;

	// stage control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			done_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				done_s1  <= '0;
			end else if (s1_finish) begin
				valid_s1 <= 1'b0;
			end else if (out_load) begin
				done_s1 <= done_s1 | pick_oh;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (face.ready) out_valid_q <= 1'b0;
		end
	end

	// triangle result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			back_q  <= LABEL_W'(cur_s1);
			front_q <= LABEL_W'(front_sel);
			v0x_q   <= bx;
			v0y_q   <= by;
			v0z_q   <= bz;
			v1x_q   <= bx + VERT_W'(off_1[2]);
			v1y_q   <= by + VERT_W'(off_1[1]);
			v1z_q   <= bz + VERT_W'(off_1[0]);
			v2x_q   <= bx + VERT_W'(off_2[2]);
			v2y_q   <= by + VERT_W'(off_2[1]);
			v2z_q   <= bz + VERT_W'(off_2[0]);
			last_q  <= last_tri;
		end
	end

	assign face.valid         = out_valid_q;
	assign face.back_region   = back_q;
	assign face.front_region  = front_q;
	assign face.v0_x          = v0x_q;
	assign face.v0_y          = v0y_q;
	assign face.v0_z          = v0z_q;
	assign face.v1_x          = v1x_q;
	assign face.v1_y          = v1y_q;
	assign face.v1_z          = v1z_q;
	assign face.v2_x          = v2x_q;
	assign face.v2_y          = v2y_q;
	assign face.v2_z          = v2z_q;
	assign face.last_of_voxel = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/vrbf_checker.sv =====
// port-level checks for the voxel boundary face block, with its bind
`default_nettype none

module vrbf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          face_valid,
	input wire logic                          face_ready,
	input wire logic [vrbf_pkg::LABEL_W-1:0]  back_region,
	input wire logic [vrbf_pkg::LABEL_W-1:0]  front_region,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v0_x,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v0_y,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v0_z,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v1_x,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v1_y,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v1_z,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v2_x,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v2_y,
	input wire logic [vrbf_pkg::VERT_W-1:0]   v2_z,
	input wire logic                          last_of_voxel
);
	import vrbf_pkg::*;

	// corner deltas from the first vertex, each must be 0 or 1
	logic [VERT_W-1:0] d1x, d1y, d1z, d2x, d2y, d2z;
	logic              near_ok;

	assign d1x = v1_x - v0_x;
	assign d1y = v1_y - v0_y;
	assign d1z = v1_z - v0_z;
	assign d2x = v2_x - v0_x;
	assign d2y = v2_y - v0_y;
	assign d2z = v2_z - v0_z;
	assign near_ok = (d1x[VERT_W-1:1] == '0) && (d1y[VERT_W-1:1] == '0) &&
		(d1z[VERT_W-1:1] == '0) && (d2x[VERT_W-1:1] == '0) &&
		(d2y[VERT_W-1:1] == '0) && (d2z[VERT_W-1:1] == '0);

	// a stalled triangle holds its regions, v1_x, v2_y and last_of_voxel
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && !face_ready |=> face_valid && $stable(back_region) &&
		$stable(front_region) && $stable(v1_x) && $stable(v2_y) &&
		$stable(last_of_voxel))
		else $error("face transaction changed while stalled");

	// a face only separates different regions
	a_regions_differ: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> back_region != front_region)
		else $error("face between equal regions");

	// vertices sit on the corners of one voxel
	a_vertex_near: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> near_ok)
		else $error("vertex off the voxel corner lattice");

	// v1 differs from both v0 and v2
	a_vertex_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> ((v1_x != v2_x) || (v1_y != v2_y) || (v1_z != v2_z)) &&
		((v1_x != v0_x) || (v1_y != v0_y) || (v1_z != v0_z)))
		else $error("degenerate triangle");

endmodule

bind voxel_region_boundary_faces vrbf_checker u_vrbf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.face_valid    (face.valid),
	.face_ready    (face.ready),
	.back_region   (face.back_region),
	.front_region  (face.front_region),
	.v0_x          (face.v0_x),
	.v0_y          (face.v0_y),
	.v0_z          (face.v0_z),
	.v1_x          (face.v1_x),
	.v1_y          (face.v1_y),
	.v1_z          (face.v1_z),
	.v2_x          (face.v2_x),
	.v2_y          (face.v2_y),
	.v2_z          (face.v2_z),
	.last_of_voxel (face.last_of_voxel)
);

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the voxel region boundary face extractor: self-checking, random and directed
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vrbf_pkg::*;

	localparam int MAX_DIM     = DEF_MAX_DIM;
	localparam int RAND_ITEMS  = 45;
	localparam int DRAIN_GAP   = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int RESET_LEN   = 12;
	localparam logic [CFG_IDX_W-1:0] IDX_TOP = {CFG_IDX_W{1'b1}};

	// one triangle as it leaves the face channel
	typedef struct packed {
		logic [LABEL_W-1:0] back_region;
		logic [LABEL_W-1:0] front_region;
		logic [VERT_W-1:0]  v0_x;
		logic [VERT_W-1:0]  v0_y;
		logic [VERT_W-1:0]  v0_z;
		logic [VERT_W-1:0]  v1_x;
		logic [VERT_W-1:0]  v1_y;
		logic [VERT_W-1:0]  v1_z;
		logic [VERT_W-1:0]  v2_x;
		logic [VERT_W-1:0]  v2_y;
		logic [VERT_W-1:0]  v2_z;
		logic               last_of_voxel;
	} face_tri_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	vrbf_vox_if  vox ();
	vrbf_face_if face ();

	voxel_region_boundary_faces uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vox       (vox),
		.face      (face),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// shadow of the block: registers, plane of labels, scan position
	logic [CFG_W-1:0]   shadow_size_x;
	logic [CFG_W-1:0]   shadow_size_y;
	logic [CFG_W-1:0]   shadow_size_z;
	logic               shadow_flip;
	logic [LABEL_W-1:0] plane_mem [MAX_DIM*MAX_DIM];
	logic [LABEL_W-1:0] last_label;
	int unsigned        scan_x;
	int unsigned        scan_y;
	int unsigned        scan_z;

	face_tri_t          faces_due [$];
	int                 fail_count = 0;
	int                 src_idle_pct = 0;
	int                 dst_idle_pct = 0;
	logic               rx_hold;
	event               hold_off_ev;
	logic [LABEL_W-1:0] palette [3];

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// corner offset {dx,dy,dz} of vertex a or b of one triangle of a face
	function automatic logic [2:0] corner_off(input face_t f, input bit second_tri,
			input bit vtx_b);
		logic [2:0] off;
		off = 3'b000;
		case (f)
			FACE_Z: off = second_tri ? (vtx_b ? 3'b110 : 3'b010) : (vtx_b ? 3'b100 : 3'b110);
			FACE_Y: off = second_tri ? (vtx_b ? 3'b101 : 3'b100) : (vtx_b ? 3'b001 : 3'b101);
			FACE_X: off = second_tri ? (vtx_b ? 3'b011 : 3'b001) : (vtx_b ? 3'b010 : 3'b011);
			default: off = 3'b000;
		endcase
		return off;
	endfunction

	// two triangles covering one face of the voxel at the scan position
	function automatic void queue_face(input face_t f, input logic [LABEL_W-1:0] back,
			input logic [LABEL_W-1:0] front);
		face_tri_t  ft;
		logic [2:0] oa;
		logic [2:0] ob;
		for (int t = 0; t < 2; t++) begin
			oa = corner_off(f, t[0], shadow_flip);
			ob = corner_off(f, t[0], !shadow_flip);
			ft.back_region   = back;
			ft.front_region  = front;
			ft.v0_x          = VERT_W'(scan_x);
			ft.v0_y          = VERT_W'(scan_y);
			ft.v0_z          = VERT_W'(scan_z);
			ft.v1_x          = VERT_W'(scan_x + oa[2]);
			ft.v1_y          = VERT_W'(scan_y + oa[1]);
			ft.v1_z          = VERT_W'(scan_z + oa[0]);
			ft.v2_x          = VERT_W'(scan_x + ob[2]);
			ft.v2_y          = VERT_W'(scan_y + ob[1]);
			ft.v2_z          = VERT_W'(scan_z + ob[0]);
			ft.last_of_voxel = 1'b0;
			faces_due.insert(faces_due.size(), ft);
		end
	endfunction

	// expected triangles of one accepted voxel, then advance the scan
	function automatic void predict_voxel(input logic [LABEL_W-1:0] label);
		int unsigned        slot;
		int                 first;
		logic [LABEL_W-1:0] nbr;
		slot  = scan_y * MAX_DIM + scan_z;
		first = faces_due.size();
		if (scan_z != 0 && last_label != label)
			queue_face(FACE_Z, label, last_label);
		if (scan_y != 0) begin
			nbr = plane_mem[slot - MAX_DIM];
			if (nbr != label)
				queue_face(FACE_Y, label, nbr);
		end
		if (scan_x != 0) begin
			nbr = plane_mem[slot];
			if (nbr != label)
				queue_face(FACE_X, label, nbr);
		end
		if (faces_due.size() > first)
			faces_due[faces_due.size() - 1].last_of_voxel = 1'b1;
		plane_mem[slot] = label;
		last_label      = label;
		scan_z++;
		if (scan_z >= eff_dim(shadow_size_z)) begin
			scan_z = 0;
			scan_y++;
			if (scan_y >= eff_dim(shadow_size_y)) begin
				scan_y = 0;
				scan_x++;
				if (scan_x >= eff_dim(shadow_size_x))
					scan_x = 0;
			end
		end
	endfunction

	function automatic string tri_text(input face_tri_t f);
		return $sformatf("back %h front %h v0 (%0d,%0d,%0d) v1 (%0d,%0d,%0d) v2 (%0d,%0d,%0d) last %b",
			f.back_region, f.front_region, f.v0_x, f.v0_y, f.v0_z,
			f.v1_x, f.v1_y, f.v1_z, f.v2_x, f.v2_y, f.v2_z, f.last_of_voxel);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("[%0t] %s", $time, msg);
	endfunction

	// face receiver: random stalls, forced low during a hold-off
	initial begin
		face.ready = 1'b0;
		forever begin
			@(posedge clk);
			face.ready <= !rx_hold && ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// long receiver hold-off, counted here
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(hold_off_ev);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// triangle checker against the oldest expected transaction
	always @(posedge clk) begin
		face_tri_t seen;
		face_tri_t want;
		if (face.valid && face.ready) begin
			seen.back_region   = face.back_region;
			seen.front_region  = face.front_region;
			seen.v0_x          = face.v0_x;
			seen.v0_y          = face.v0_y;
			seen.v0_z          = face.v0_z;
			seen.v1_x          = face.v1_x;
			seen.v1_y          = face.v1_y;
			seen.v1_z          = face.v1_z;
			seen.v2_x          = face.v2_x;
			seen.v2_y          = face.v2_y;
			seen.v2_z          = face.v2_z;
			seen.last_of_voxel = face.last_of_voxel;
			if (faces_due.size() == 0) begin
				note_failure({"unexpected triangle: ", tri_text(seen)});
			end else begin
				want = faces_due.pop_front();
				if (seen !== want)
					note_failure({"triangle mismatch\n  expected ", tri_text(want),
						"\n  actual   ", tri_text(seen)});
			end
		end
	end

	// run limit
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic set_idling(input int src_pct, input int dst_pct);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
	endtask

	// offer one voxel, with random idle cycles ahead of it
	task automatic send_voxel(input logic [LABEL_W-1:0] label);
		while ($urandom_range(99) < src_idle_pct) begin
			vox.valid        <= 1'b0;
			vox.region_label <= LABEL_W'($urandom);
			@(posedge clk);
		end
		vox.valid        <= 1'b1;
		vox.region_label <= label;
		do @(posedge clk); while (!vox.ready);
		predict_voxel(label);
	endtask

	// stop offering, wait for every expected triangle and the block to settle
	task automatic wait_drained();
		vox.valid <= 1'b0;
		while (faces_due.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIZE_X: shadow_size_x = data;
			REG_SIZE_Y: shadow_size_y = data;
			REG_SIZE_Z: shadow_size_z = data;
			REG_FLIP:   shadow_flip   = data[0];
			default:    ;
		endcase
		if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z) begin
			scan_x = 0;
			scan_y = 0;
			scan_z = 0;
		end
	endtask

	task automatic set_volume(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
			input logic [CFG_W-1:0] sz, input logic [CFG_W-1:0] flip_data);
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_FLIP, flip_data);
	endtask

	function automatic void new_palette();
		foreach (palette[i])
			palette[i] = LABEL_W'($urandom);
	endfunction

	// mostly a few repeating labels so that equal neighbours occur
	function automatic logic [LABEL_W-1:0] pick_label();
		if ($urandom_range(3) == 0)
			return LABEL_W'($urandom);
		return palette[$urandom_range(2)];
	endfunction

	// after reset every voxel is a volume of its own: nothing to compare with
	task automatic test_power_on_volume();
		send_voxel('0);
		send_voxel('1);
		send_voxel(16'h1234);
		wait_drained();
	endtask

	// 2x2x2 volume, all bits toggled, corner voxel with three differing faces
	task automatic test_small_volume_faces();
		logic [LABEL_W-1:0] labels [8];
		labels = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
			16'h5555, 16'h1234, 16'h8001, 16'h7FFE};
		for (int f = 0; f < 2; f++) begin
			set_volume(9'd2, 9'd2, 9'd2, CFG_W'(f));
			foreach (labels[i])
				send_voxel(labels[i]);
			wait_drained();
		end
	endtask

	// size writes return to origin, flip and spare indexes leave the scan alone
	task automatic test_register_writes_mid_volume();
		new_palette();
		set_volume(9'd2, 9'd3, 9'd2, 9'd0);
		repeat (5) send_voxel(pick_label());
		wait_drained();
		write_reg(REG_SIZE_Y, 9'd3);
		repeat (7) send_voxel(pick_label());
		wait_drained();
		write_reg(REG_FLIP, 9'h1FF);
		repeat (8) send_voxel(pick_label());
		wait_drained();
		for (logic [CFG_IDX_W:0] i = (CFG_IDX_W+1)'(REG_FLIP + 1); i <= IDX_TOP; i++)
			write_reg(i[CFG_IDX_W-1:0], CFG_W'($urandom));
		repeat (9) send_voxel(pick_label());
		wait_drained();
		write_reg(REG_FLIP, 9'h1FE);
		repeat (4) send_voxel(pick_label());
		wait_drained();
	endtask

	// small random volumes under the three idling patterns, a few cut short
	task automatic test_random_volumes();
		int sent;
		int nvox;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       set_idling(16, 87);
				1:       set_idling(87, 16);
				default: set_idling(0, 0);
			endcase
			sent = 0;
			while (sent < RAND_ITEMS / 3) begin
				if (sent == 0 || $urandom_range(2) != 0) begin
					wait_drained();
					set_volume(CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(1, 3)),
						CFG_W'($urandom_range(1, 3)), CFG_W'($urandom));
				end
				nvox = eff_dim(shadow_size_x) * eff_dim(shadow_size_y) * eff_dim(shadow_size_z);
				if ($urandom_range(9) == 0)
					nvox = $urandom_range(1, nvox);
				if (nvox > RAND_ITEMS / 3 - sent)
					nvox = RAND_ITEMS / 3 - sent;
				new_palette();
				repeat (nvox) begin
					send_voxel(pick_label());
					sent++;
				end
			end
			wait_drained();
		end
	endtask

	// receiver holds off while voxels keep coming, then the sender pauses for a drain
	task automatic test_output_backpressure();
		set_idling(0, 0);
		set_volume(9'd3, 9'd3, 9'd3, 9'd1);
		-> hold_off_ev;
		repeat (27) send_voxel(LABEL_W'($urandom));
		wait_drained();
	endtask

	// zero sizes act as one, oversized sizes as the maximum
	task automatic test_size_extremes();
		set_idling(0, 0);
		set_volume(9'd0, 9'd0, 9'h1FF, 9'd0);
		new_palette();
		repeat (4) send_voxel(pick_label());
		wait_drained();
		set_volume(9'h100, 9'd1, 9'd0, 9'd1);
		new_palette();
		repeat (4) send_voxel(pick_label());
		wait_drained();
		set_volume(9'd1, 9'h12C, 9'd1, 9'd0);
		new_palette();
		repeat (4) send_voxel(pick_label());
		wait_drained();
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_SIZE_X;
		cfg_data         = '0;
		vox.valid        = 1'b0;
		vox.region_label = '0;
		shadow_size_x    = 9'd1;
		shadow_size_y    = 9'd1;
		shadow_size_z    = 9'd1;
		shadow_flip      = 1'b0;
		last_label       = '0;
		scan_x           = 0;
		scan_y           = 0;
		scan_z           = 0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(16, 87);
		test_power_on_volume();
		test_small_volume_faces();
		test_register_writes_mid_volume();
		test_random_volumes();
		test_output_backpressure();
		test_size_extremes();
		wait_drained();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
